// ===== src/mtu_pkg.sv =====
`timescale 1ns / 1ps
// mtu_pkg: shared constants, mode codes and helper functions for the matrix transform unit
// depends on nothing; imported by every module of the block
package mtu_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed widths of the beat fields
   localparam int MODE_W  = 3;
   localparam int ROW_W   = 2;
   localparam int VALUE_W = 32;
   localparam int OUT_W   = 32;

   localparam int DIM     = 4;
   localparam int CELLS   = DIM * DIM;
   localparam int SHADOWS = (DIM - 1) * DIM;
   localparam int CELL_W  = 4;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MULTIPLY  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TRANSFORM = 3'd3;
   localparam logic [MODE_W-1:0] MODE_IDENTITY  = 3'd4;

   localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

   // work carried by the product stage
   typedef enum logic [1:0] {
      OP_XFORM,
      OP_SHADOW,
      OP_COMMIT,
      OP_TRANSLATE
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic [ROW_W-1:0] row;
   } stage_ctl_type;

   // product width: full signed product, or a matrix entry shifted up by the fraction
   function automatic int prod_width(input int dw, input int fb);
      int r;
      r = 2 * dw;
      if (dw + fb > r) begin
         r = dw + fb;
      end
      return r;
   endfunction

endpackage

// ===== src/mtu_lane.sv =====
`timescale 1ns / 1ps
// mtu_lane: one multiplier lane, forms a registered product of a vector element and a matrix entry
// depends on mtu_pkg
module mtu_lane import mtu_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            load,
   input  logic                                            shift_sel,
   input  logic signed [DATA_WIDTH-1:0]                    opnd_a,
   input  logic signed [DATA_WIDTH-1:0]                    opnd_b,
   output logic signed [prod_width(DATA_WIDTH, FRAC_BITS)-1:0] product
);

   localparam int PROD_W = prod_width(DATA_WIDTH, FRAC_BITS);

   logic signed [2*DATA_WIDTH-1:0] mul_w;
   logic signed [PROD_W-1:0]       shl_w;
   logic signed [PROD_W-1:0]       product_in;
   logic signed [PROD_W-1:0]       product_ff;

   assign mul_w = opnd_a * opnd_b;
   // translate folds the old row 3 in at unit weight
   assign shl_w = PROD_W'(opnd_b) <<< FRAC_BITS;
   assign product_in = shift_sel ? shl_w : PROD_W'(mul_w);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== src/mtu_merge.sv =====
`timescale 1ns / 1ps
// mtu_merge: adds four lane products of one column, shifts out the fraction and saturates
// depends on mtu_pkg
module mtu_merge import mtu_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic signed [prod_width(DATA_WIDTH, FRAC_BITS)-1:0] prod_0,
   input  logic signed [prod_width(DATA_WIDTH, FRAC_BITS)-1:0] prod_1,
   input  logic signed [prod_width(DATA_WIDTH, FRAC_BITS)-1:0] prod_2,
   input  logic signed [prod_width(DATA_WIDTH, FRAC_BITS)-1:0] prod_3,
   output logic signed [DATA_WIDTH-1:0]                        result
);

   localparam int PROD_W = prod_width(DATA_WIDTH, FRAC_BITS);
   localparam int SUM_W  = PROD_W + 2;
   localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [SUM_W-1:0] sum_w;
   logic signed [SUM_W-1:0] shifted_w;

   assign sum_w = SUM_W'(prod_0) + SUM_W'(prod_1) + SUM_W'(prod_2) + SUM_W'(prod_3);
   assign shifted_w = sum_w >>> FRAC_BITS;

   always_comb begin
      if (shifted_w > SUM_W'(DMAX)) begin
         result = DMAX;
      end else if (shifted_w < SUM_W'(DMIN)) begin
         result = DMIN;
      end else begin
         result = DATA_WIDTH'(shifted_w);
      end
   end

endmodule

// ===== src/matrix4_transform_unit.sv =====
`timescale 1ns / 1ps
// matrix4_transform_unit: 4x4 fixed-point matrix engine for vertex transforms, top level
// depends on mtu_pkg, mtu_lane, mtu_merge
//
//  channel   ports                                   direction   handshake
//  req       req_mode req_row_index req_value_0..3   in          req_valid / req_stall
//  rsp       rsp_out_0..3                            out         rsp_valid / rsp_stall
//
// beats: load row, set identity, transform and multiply rows 0..2 take one beat a cycle
//   while req_stall is low; multiply row 3 and translate stall the next beat until the
//   merge stage has written the matrix back, since the next beat must see that matrix
// path: a transform result passes the lane product registers, then the output register, to rsp
// reset: synchronous, matrix returns to identity, pipeline and output empty
// stalls: rsp_stall holds the output register, and the product stage behind it only
//   when it holds a transform
module matrix4_transform_unit import mtu_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [ROW_W-1:0]          req_row_index,
   input  logic signed [VALUE_W-1:0] req_value_0,
   input  logic signed [VALUE_W-1:0] req_value_1,
   input  logic signed [VALUE_W-1:0] req_value_2,
   input  logic signed [VALUE_W-1:0] req_value_3,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_W-1:0]   rsp_out_0,
   output logic signed [OUT_W-1:0]   rsp_out_1,
   output logic signed [OUT_W-1:0]   rsp_out_2,
   output logic signed [OUT_W-1:0]   rsp_out_3
);

   localparam int PROD_W = prod_width(DATA_WIDTH, FRAC_BITS);
   localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   // 1.0, clipped when the fraction leaves no room for it
   localparam logic signed [DATA_WIDTH-1:0] ONE =
      (FRAC_BITS >= DATA_WIDTH - 1) ? DMAX : (DATA_WIDTH'(1) << FRAC_BITS);

   // matrix, row-major, and pending rows 0..2 of a multiply
   logic signed [DATA_WIDTH-1:0] mat_ff [CELLS];
   logic signed [DATA_WIDTH-1:0] mat_in [CELLS];
   logic signed [DATA_WIDTH-1:0] shadow_ff [SHADOWS];
   logic signed [DATA_WIDTH-1:0] shadow_in [SHADOWS];

   // product stage control and output register
   stage_ctl_type p_ctl_ff, p_ctl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_data_ff [DIM];
   logic signed [DATA_WIDTH-1:0] rsp_data_in [DIM];

   // beat operands, the low DATA_WIDTH bits of each value
   logic signed [DATA_WIDTH-1:0] vec [DIM];

   logic   accept;
   logic   out_free;
   logic   p_adv;
   logic   p_hazard;
   logic   acc_lanes;
   logic   acc_load;
   logic   acc_ident;
   op_type acc_op;
   logic   sel_xform;
   logic   sel_translate;

   logic signed [PROD_W-1:0]     prod [DIM][DIM];   // [column][k]
   logic signed [DATA_WIDTH-1:0] col_res [DIM];

   assign vec[0] = signed'(req_value_0[DATA_WIDTH-1:0]);
   assign vec[1] = signed'(req_value_1[DATA_WIDTH-1:0]);
   assign vec[2] = signed'(req_value_2[DATA_WIDTH-1:0]);
   assign vec[3] = signed'(req_value_3[DATA_WIDTH-1:0]);

   // handshake: the product stage moves unless it holds a transform that cannot leave
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign p_adv     = !p_ctl_ff.valid || (p_ctl_ff.op != OP_XFORM) || out_free;
   // a matrix write-back in flight blocks the next beat until it is written
   assign p_hazard  = p_ctl_ff.valid &&
                      ((p_ctl_ff.op == OP_COMMIT) || (p_ctl_ff.op == OP_TRANSLATE));
   assign req_stall = !p_adv || p_hazard;
   assign accept    = req_valid && !req_stall;

   // mode decode
   always_comb begin
      acc_lanes = 1'b0;
      acc_load  = 1'b0;
      acc_ident = 1'b0;
      acc_op    = OP_XFORM;
      case (req_mode)
         MODE_LOAD: begin
            acc_load = 1'b1;
         end
         MODE_MULTIPLY: begin
            acc_lanes = 1'b1;
            acc_op    = (req_row_index == LAST_ROW) ? OP_COMMIT : OP_SHADOW;
         end
         MODE_TRANSLATE: begin
            acc_lanes = 1'b1;
            acc_op    = OP_TRANSLATE;
         end
         MODE_TRANSFORM: begin
            acc_lanes = 1'b1;
            acc_op    = OP_XFORM;
         end
         MODE_IDENTITY: begin
            acc_ident = 1'b1;
         end
         default: begin
            // unused codes are taken and dropped
         end
      endcase
   end

   assign sel_xform     = (req_mode == MODE_TRANSFORM);
   assign sel_translate = (req_mode == MODE_TRANSLATE);

   // sixteen lanes: lane (j,k) feeds column j
   // transform uses m[j][k]*v[k]; multiply and translate use v[k]*m[k][j]
   for (genvar j = 0; j < DIM; j++) begin : g_col
      for (genvar k = 0; k < DIM; k++) begin : g_k
         mtu_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
         ) u_lane (
            .clock     (clock),
            .load      (accept && acc_lanes),
            .shift_sel (sel_translate && (k == DIM - 1)),
            .opnd_a    (vec[k]),
            .opnd_b    (sel_xform ? mat_ff[j*DIM+k] : mat_ff[k*DIM+j]),
            .product   (prod[j][k])
         );
      end

      mtu_merge #(
         .DATA_WIDTH (DATA_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_merge (
         .prod_0 (prod[j][0]),
         .prod_1 (prod[j][1]),
         .prod_2 (prod[j][2]),
         .prod_3 (prod[j][3]),
         .result (col_res[j])
      );
   end

   // product stage control
   always_comb begin
      p_ctl_in = p_ctl_ff;
      if (p_adv) begin
         p_ctl_in.valid = accept && acc_lanes;
         p_ctl_in.op    = acc_op;
         p_ctl_in.row   = req_row_index;
      end
   end

   // matrix and shadow updates: direct writes at the beat, merged writes at stage exit
   always_comb begin
      mat_in    = mat_ff;
      shadow_in = shadow_ff;
      if (accept && acc_load) begin
         for (int c = 0; c < DIM; c++) begin
            mat_in[{req_row_index, 2'(c)}] = vec[c];
         end
      end else if (accept && acc_ident) begin
         for (int c = 0; c < CELLS; c++) begin
            mat_in[CELL_W'(c)] = ((c % (DIM + 1)) == 0) ? ONE : '0;
         end
      end
      if (p_adv && p_ctl_ff.valid) begin
         case (p_ctl_ff.op)
            OP_SHADOW: begin
               for (int c = 0; c < DIM; c++) begin
                  shadow_in[{p_ctl_ff.row, 2'(c)}] = col_res[c];
               end
            end
            OP_COMMIT: begin
               for (int c = 0; c < SHADOWS; c++) begin
                  mat_in[CELL_W'(c)] = shadow_ff[CELL_W'(c)];
               end
               for (int c = 0; c < DIM; c++) begin
                  mat_in[CELL_W'(SHADOWS+c)] = col_res[c];
               end
            end
            OP_TRANSLATE: begin
               for (int c = 0; c < DIM; c++) begin
                  mat_in[CELL_W'(SHADOWS+c)] = col_res[c];
               end
            end
            default: begin
               // transform leaves the matrix alone
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (p_adv && p_ctl_ff.valid && (p_ctl_ff.op == OP_XFORM)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = col_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctl_ff     <= '{valid: 1'b0, op: OP_XFORM, row: '0};
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CELLS; c++) begin
            mat_ff[CELL_W'(c)] <= ((c % (DIM + 1)) == 0) ? ONE : '0;
         end
      end else begin
         p_ctl_ff     <= p_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         mat_ff       <= mat_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      shadow_ff   <= shadow_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_0 = OUT_W'(rsp_data_ff[0]);
   assign rsp_out_1 = OUT_W'(rsp_data_ff[1]);
   assign rsp_out_2 = OUT_W'(rsp_data_ff[2]);
   assign rsp_out_3 = OUT_W'(rsp_data_ff[3]);

endmodule

// ===== verif/tb_matrix4_transform_unit.sv =====
`timescale 1ns / 1ps
// tb_matrix4_transform_unit: self-checking bench for the 4x4 fixed-point matrix engine
// depends on mtu_pkg and matrix4_transform_unit; a scripted opening, then random beats
// checked against a Q16.16 matrix model kept inside the bench
module tb_matrix4_transform_unit;
   import mtu_pkg::*;

   // accumulator wide enough for four 32x32 products plus a shifted matrix entry
   localparam int ACC_W = 72;
   localparam logic signed [ACC_W-1:0] Q_MAX = 72'sh7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] Q_MIN = -72'sh8000_0000;

   // mode codes the block must ignore
   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

   // Q16.16 operands used by the scripted part
   localparam logic [VALUE_W-1:0] ONE     = 32'h0001_0000;
   localparam logic [VALUE_W-1:0] NEG_ONE = 32'hFFFF_0000;
   localparam logic [VALUE_W-1:0] QMAX    = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] QMIN    = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] TWO     = 32'h0002_0000;
   localparam logic [VALUE_W-1:0] HALF    = 32'h0000_8000;
   localparam logic [VALUE_W-1:0] QUARTER = 32'h0000_4000;

   localparam int RANDOM_BEATS = 1100;
   localparam int MAX_IDLE     = 13;

   typedef logic [DIM-1:0][VALUE_W-1:0] quad_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ROW_W-1:0]  row;
      quad_type          val;
   } mtx_beat_type;

   typedef struct packed {
      mtx_beat_type beat;
      logic         pinned;   // expected vertex typed into the script
      quad_type     want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode      = MODE_IDENTITY;
   logic [ROW_W-1:0]          req_row_index = '0;
   logic signed [VALUE_W-1:0] req_value_0   = '0;
   logic signed [VALUE_W-1:0] req_value_1   = '0;
   logic signed [VALUE_W-1:0] req_value_2   = '0;
   logic signed [VALUE_W-1:0] req_value_3   = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic signed [OUT_W-1:0]   rsp_out_0;
   logic signed [OUT_W-1:0]   rsp_out_1;
   logic signed [OUT_W-1:0]   rsp_out_2;
   logic signed [OUT_W-1:0]   rsp_out_3;

   // model state: current matrix row-major, pending product rows, which were written
   logic signed [VALUE_W-1:0] cur_mtx [CELLS];
   logic signed [VALUE_W-1:0] shadow_rows [SHADOWS];
   logic [DIM-2:0]            shadow_seen;

   quad_type       pending_vertices[$];
   script_row_type opening_plan[$];
   int             fault_count = 0;
   int             real_beats  = 0;
   bit             req_rush    = 1'b0;
   bit             rsp_rush    = 1'b0;

   matrix4_transform_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_row_index (req_row_index),
      .req_value_0   (req_value_0),
      .req_value_1   (req_value_1),
      .req_value_2   (req_value_2),
      .req_value_3   (req_value_3),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_0     (rsp_out_0),
      .rsp_out_1     (rsp_out_1),
      .rsp_out_2     (rsp_out_2),
      .rsp_out_3     (rsp_out_3)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // matrix model
   // ---------------------------------------------------------------------------

   // arithmetic shift by the fraction (floor), then clip to the 32-bit signed range
   function automatic logic [VALUE_W-1:0] fold_q(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] s;
      s = acc >>> FRAC_BITS_DEF;
      if (s > Q_MAX) begin
         s = Q_MAX;
      end else if (s < Q_MIN) begin
         s = Q_MIN;
      end
      return s[VALUE_W-1:0];
   endfunction

   function automatic void load_unit_matrix();
      for (int i = 0; i < CELLS; i++) begin
         cur_mtx[i] = (i % (DIM + 1) == 0) ? ONE : '0;
      end
   endfunction

   // advance the model by one accepted beat; returns 1 with the vertex for a transform
   function automatic bit apply_beat(input mtx_beat_type b, output quad_type vertex);
      logic signed [ACC_W-1:0]   acc;
      logic signed [ACC_W-1:0]   lhs;
      logic signed [ACC_W-1:0]   rhs;
      logic signed [VALUE_W-1:0] v [DIM];
      logic signed [VALUE_W-1:0] fresh [DIM];
      bit                        emits;
      emits  = 1'b0;
      vertex = '0;
      for (int k = 0; k < DIM; k++) begin
         v[k] = b.val[k];
      end
      case (b.mode)
         MODE_LOAD: begin
            for (int j = 0; j < DIM; j++) begin
               cur_mtx[b.row * DIM + j] = v[j];
            end
         end
         MODE_MULTIPLY: begin
            // new row = operand row times the matrix as it stands on this beat
            for (int j = 0; j < DIM; j++) begin
               acc = '0;
               for (int k = 0; k < DIM; k++) begin
                  lhs = v[k];
                  rhs = cur_mtx[k * DIM + j];
                  acc += lhs * rhs;
               end
               fresh[j] = fold_q(acc);
            end
            if (b.row != LAST_ROW) begin
               for (int j = 0; j < DIM; j++) begin
                  shadow_rows[b.row * DIM + j] = fresh[j];
               end
               shadow_seen[b.row] = 1'b1;
            end else begin
               // last row commits whatever the shadow holds, stale rows included
               for (int j = 0; j < SHADOWS; j++) begin
                  cur_mtx[j] = shadow_rows[j];
               end
               for (int j = 0; j < DIM; j++) begin
                  cur_mtx[SHADOWS + j] = fresh[j];
               end
            end
         end
         MODE_TRANSLATE: begin
            // row 3 += x*row0 + y*row1 + z*row2, fourth operand unused
            for (int j = 0; j < DIM; j++) begin
               acc = cur_mtx[SHADOWS + j];
               acc = acc <<< FRAC_BITS_DEF;
               for (int k = 0; k < DIM - 1; k++) begin
                  lhs = v[k];
                  rhs = cur_mtx[k * DIM + j];
                  acc += lhs * rhs;
               end
               fresh[j] = fold_q(acc);
            end
            for (int j = 0; j < DIM; j++) begin
               cur_mtx[SHADOWS + j] = fresh[j];
            end
         end
         MODE_TRANSFORM: begin
            for (int j = 0; j < DIM; j++) begin
               acc = '0;
               for (int k = 0; k < DIM; k++) begin
                  lhs = cur_mtx[j * DIM + k];
                  rhs = v[k];
                  acc += lhs * rhs;
               end
               vertex[j] = fold_q(acc);
            end
            emits = 1'b1;
         end
         MODE_IDENTITY: begin
            load_unit_matrix();
         end
         default: begin
            // spare modes leave everything alone
         end
      endcase
      return emits;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic quad_type pack4(input logic [VALUE_W-1:0] a, b, c, d);
      quad_type q;
      q[0] = a;
      q[1] = b;
      q[2] = c;
      q[3] = d;
      return q;
   endfunction

   // mostly modest Q16.16 values so results do not always clip, with some full range
   function automatic logic [VALUE_W-1:0] draw_q16();
      logic [VALUE_W-1:0] r;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: r = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         6:                r = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         7, 8:             r = $urandom;
         default: begin
            case ($urandom_range(0, 6))
               0:       r = QMAX;
               1:       r = QMIN;
               2:       r = '0;
               3:       r = ONE;
               4:       r = NEG_ONE;
               5:       r = '1;
               default: r = 32'h0000_0001;
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic mtx_beat_type random_beat(input logic [MODE_W-1:0] mode);
      mtx_beat_type b;
      b.mode = mode;
      b.row  = ROW_W'($urandom_range(0, DIM - 1));
      for (int k = 0; k < DIM; k++) begin
         b.val[k] = draw_q16();
      end
      return b;
   endfunction

   task automatic add_step(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                           input quad_type val, input bit pinned, input quad_type want);
      script_row_type s;
      s.beat.mode = mode;
      s.beat.row  = row;
      s.beat.val  = val;
      s.pinned    = pinned;
      s.want      = want;
      opening_plan.push_back(s);
   endtask

   // drive one beat after a random idle gap, hold it until accepted, then predict
   task automatic send_beat(input mtx_beat_type b, input bit pinned, input quad_type want);
      int       gap;
      quad_type vertex;
      if ($urandom_range(0, 39) == 0) begin
         req_rush = !req_rush;
      end
      gap = req_rush ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= b.mode;
      req_row_index <= b.row;
      req_value_0   <= b.val[0];
      req_value_1   <= b.val[1];
      req_value_2   <= b.val[2];
      req_value_3   <= b.val[3];
      do @(posedge clock); while (req_stall);
      // accepted at this edge
      if (apply_beat(b, vertex)) begin
         pending_vertices.push_back(pinned ? want : vertex);
      end
      if (b.mode <= MODE_IDENTITY) begin
         real_beats++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_seq
      mtx_beat_type b;
      int           pick;
      int           depth;
      load_unit_matrix();
      shadow_seen = '0;
      for (int i = 0; i < SHADOWS; i++) begin
         shadow_rows[i] = '0;
      end

      // opening script: identity after reset passes vectors through unchanged
      add_step(MODE_TRANSFORM, 2'd0, pack4(ONE, NEG_ONE, QMAX, QMIN),
               1'b1, pack4(ONE, NEG_ONE, QMAX, QMIN));
      // spare modes must not touch the matrix or produce a beat
      add_step(MODE_SPARE_A, 2'd3, pack4(QMAX, QMAX, QMAX, QMAX), 1'b0, '0);
      add_step(MODE_SPARE_B, 2'd1, pack4(QMIN, QMIN, QMIN, QMIN), 1'b0, '0);
      add_step(MODE_SPARE_C, 2'd2, pack4(TWO, TWO, TWO, TWO), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd3, pack4(32'h1, '1, 32'h1234_5678, 32'hEDCB_A988),
               1'b1, pack4(32'h1, '1, 32'h1234_5678, 32'hEDCB_A988));
      // extreme rows: sums of rows 0 and 1 clip to the positive or negative limit, rows 2 and 3 pass through
      add_step(MODE_LOAD, 2'd0, pack4(QMAX, QMAX, QMAX, QMAX), 1'b0, '0);
      add_step(MODE_LOAD, 2'd1, pack4(QMIN, QMIN, QMIN, QMIN), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd0, pack4(QMAX, QMAX, QMAX, QMAX),
               1'b1, pack4(QMAX, QMIN, QMAX, QMAX));
      add_step(MODE_TRANSFORM, 2'd0, pack4(QMIN, QMIN, QMIN, QMIN),
               1'b1, pack4(QMIN, QMAX, QMIN, QMIN));
      add_step(MODE_IDENTITY, 2'd2, pack4(QMAX, QMIN, QMAX, QMIN), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd1, pack4(QMAX, QMIN, '0, ONE),
               1'b1, pack4(QMAX, QMIN, '0, ONE));
      // full multiply sequence, commit on the last row
      add_step(MODE_MULTIPLY, 2'd0, pack4(TWO, '0, '0, '0), 1'b0, '0);
      add_step(MODE_MULTIPLY, 2'd1, pack4('0, ONE, HALF, '0), 1'b0, '0);
      add_step(MODE_MULTIPLY, 2'd2, pack4('0, '0, 32'hFFFE_8000, '0), 1'b0, '0);
      add_step(MODE_MULTIPLY, 2'd3, pack4(QUARTER, '0, '0, ONE), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd0, pack4(ONE, TWO, 32'hFFFD_0000, ONE), 1'b0, '0);
      // translate ignores its fourth operand
      add_step(MODE_TRANSLATE, 2'd0, pack4(ONE, NEG_ONE, HALF, 32'hDEAD_BEEF), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd2, pack4(ONE, ONE, ONE, ONE), 1'b0, '0);
      // partial sequence: the commit reuses stale shadow rows 0 and 2
      add_step(MODE_MULTIPLY, 2'd1, pack4(ONE, ONE, '0, '0), 1'b0, '0);
      add_step(MODE_MULTIPLY, 2'd3, pack4('0, '0, '0, ONE), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd0, pack4(TWO, NEG_ONE, HALF, ONE), 1'b0, '0);
      // translate that clips
      add_step(MODE_TRANSLATE, 2'd3, pack4(QMAX, QMIN, QMAX, '0), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd0, pack4(QMAX, QMAX, QMIN, ONE), 1'b0, '0);
      add_step(MODE_LOAD, 2'd3, pack4(ONE, '0, NEG_ONE, QMIN), 1'b0, '0);
      add_step(MODE_TRANSFORM, 2'd1, pack4(ONE, TWO, ONE, HALF), 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         send_beat(opening_plan[i].beat, opening_plan[i].pinned, opening_plan[i].want);
      end

      // random traffic, weighted toward vertices and well-formed multiply sequences
      while (real_beats < RANDOM_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_beat(random_beat(MODE_TRANSFORM), 1'b0, '0);
         end else if (pick < 48) begin
            send_beat(random_beat(MODE_LOAD), 1'b0, '0);
         end else if (pick < 63) begin
            for (int r = 0; r < DIM; r++) begin
               b     = random_beat(MODE_MULTIPLY);
               b.row = ROW_W'(r);
               send_beat(b, 1'b0, '0);
            end
         end else if (pick < 70) begin
            // lone multiply row; a commit only once every shadow row holds data
            b = random_beat(MODE_MULTIPLY);
            if (b.row == LAST_ROW && shadow_seen != '1) begin
               b.row = '0;
            end
            send_beat(b, 1'b0, '0);
         end else if (pick < 75) begin
            // sequence cut short before its commit
            depth = $urandom_range(1, DIM - 2);
            for (int r = 0; r < depth; r++) begin
               b     = random_beat(MODE_MULTIPLY);
               b.row = ROW_W'(r);
               send_beat(b, 1'b0, '0);
            end
         end else if (pick < 87) begin
            send_beat(random_beat(MODE_TRANSLATE), 1'b0, '0);
         end else if (pick < 94) begin
            send_beat(random_beat(MODE_IDENTITY), 1'b0, '0);
         end else begin
            send_beat(random_beat(MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_C))),
                      1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then keep watching while idle to catch stray beats
      while (pending_vertices.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_matrix4_transform_unit: done, clean");
      end else begin
         $display("tb_matrix4_transform_unit: done, errors");
      end
      $finish;
   end

   // receiver: random stall before each beat, with stretches of no stall
   initial begin : rsp_pacer
      int hold;
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_rush = !rsp_rush;
         end
         hold = rsp_rush ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare every accepted result beat against the oldest predicted vertex
   always @(posedge clock) begin : vertex_check
      quad_type want;
      quad_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = pack4(rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3);
         if (pending_vertices.size() == 0) begin
            if (fault_count < 10) begin
               $display("unexpected result beat: %h %h %h %h",
                        seen[0], seen[1], seen[2], seen[3]);
            end
            fault_count++;
         end else begin
            want = pending_vertices.pop_front();
            for (int j = 0; j < DIM; j++) begin
               if (seen[j] !== want[j]) begin
                  if (fault_count < 10) begin
                     $display("mismatch out_%0d: expected %h, got %h", j, want[j], seen[j]);
                  end
                  fault_count++;
               end
            end
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("tb_matrix4_transform_unit: done, errors");
      $finish;
   end

endmodule
